// ----- rtl/nsp_pkg.sv -----
// ----------------------------------------------------------------------------
// nsp_pkg
// shared types, codes and defaults of the nested scope profiler
// ----------------------------------------------------------------------------
package nsp_pkg;

    // default sizes, handed to the top level parameters
    localparam int SCOPE_COUNT_DEF   = 16;
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int STACK_DEPTH_DEF   = 256;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int SCOPE_W  = 4;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int CALLS_W  = 16;
    localparam int HPOS_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_END   = 2'd1,
        OP_STEP  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OPEN      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CHG_STK,
        S_CHG_WR,
        S_PUSH,
        S_CALLS,
        S_POP,
        S_INC_STK,
        S_INC_WR,
        S_STEP,
        S_FINISH
    } t_state;

    // stats memory read address source
    typedef enum logic [1:0] {
        SEL_TOP,
        SEL_SCOPE,
        SEL_STEP0,
        SEL_STEP_NEXT
    } t_st_sel;

    // stats memory write kind
    typedef enum logic [1:0] {
        WR_NONE,
        WR_CHARGE,
        WR_INCL,
        WR_CALL
    } t_st_wr;

    typedef struct packed {
        logic [TIME_W-1:0]  own;
        logic [TIME_W-1:0]  incl;
        logic [CALLS_W-1:0] calls;
    } t_stat;

    typedef struct packed {
        logic [TIME_W-1:0]  mark;
        logic [SCOPE_W-1:0] scope;
    } t_stack;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    stk_rd;
        logic    stk_mark;
        logic    push;
        logic    depth_dec;
        logic    st_rd;
        t_st_sel st_sel;
        t_st_wr  st_wr;
        logic    step_start;
        logic    step_adv;
        logic    step_wr;
        logic    step_done;
        logic    hist_rd;
        logic    out_load;
        logic    out_hist;
        t_status status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic depth_zero;
        logic depth_full;
        logic scope_ok;
        logic read_ok;
        logic step_last;
        logic out_free;
    } t_flags;

endpackage

// ----- rtl/nested_scope_profiler_top.sv -----
// ----------------------------------------------------------------------------
// nested_scope_profiler_top
// hierarchical scope profiler with own and inclusive time per scope
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry one word {operation, scope_id,
//   timestamp, slot}; a word is taken at a clock edge with i_valid high and
//   o_stall low
// output channel: o_valid / i_stall carry one result word per input word,
//   in order; the result sits in an output register and holds while i_stall
//   is high
// one word is worked at a time; the next word can be taken once the
//   sequencer is back in idle: a read or any rejected / ignored word goes
//   straight to the result, a begin on an empty stack pushes and counts
//   the call, a begin under an open scope first charges that scope, an end
//   charges and pops the top and, if scopes stay open, adds the time to the
//   new top's inclusive time, and a step walks every scope once
// the work is set by the read-modify-write turns on the single port stats
//   memory and the stack memory; the result register is loaded as the
//   sequencer returns to idle, and a stalled result holds the sequencer in
//   its last state until the receiver frees the output register
// reset clears the stack depth, the current stats (valid bits), the history
//   pointer and fill count, and the output valid; no clearing pass is needed
// ----------------------------------------------------------------------------
module nested_scope_profiler_top
    import nsp_pkg::*;
#(
    parameter int SCOPE_COUNT   = SCOPE_COUNT_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input words
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [SCOPE_W-1:0]  i_scope_id,
    input  logic [TIME_W-1:0]   i_timestamp,
    input  logic [SLOT_W-1:0]   i_slot,
    // result words
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TIME_W-1:0]   o_own_time,
    output logic [TIME_W-1:0]   o_inclusive_time,
    output logic [CALLS_W-1:0]  o_call_count,
    output logic [HPOS_W-1:0]   o_history_position
);

    t_cmd   cmd;
    t_flags flags;

    // sequencer: decodes the word and steps the datapath through it
    nsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_flags    (flags),
        .o_in_stall (o_stall),
        .o_cmd      (cmd)
    );

    // datapath: stack, stats, history ring and the output register
    nsp_dp #(
        .SCOPE_COUNT   (SCOPE_COUNT),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_flags            (flags),
        .i_operation        (i_operation),
        .i_scope_id         (i_scope_id),
        .i_timestamp        (i_timestamp),
        .i_slot             (i_slot),
        .i_out_stall        (i_stall),
        .o_out_valid        (o_valid),
        .o_status           (o_status),
        .o_own_time         (o_own_time),
        .o_inclusive_time   (o_inclusive_time),
        .o_call_count       (o_call_count),
        .o_history_position (o_history_position)
    );

endmodule

// ----- rtl/nsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// nsp_ctrl
// sequencer of the profiler: one word at a time through the datapath
// ----------------------------------------------------------------------------
module nsp_ctrl
    import nsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_flags i_flags,
    output logic   o_in_stall,
    output t_cmd   o_cmd
);

    t_state  r_state,     n_state;
    t_status r_status,    n_status;
    logic    r_from_hist, n_from_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_from_hist <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_from_hist <= n_from_hist;
        end
    end

    assign o_in_stall = !i_rst_n || (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_from_hist = r_from_hist;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status    = ST_OK;
                n_from_hist = 1'b0;
                n_state     = S_FINISH;
                unique case (i_flags.op)
                    OP_BEGIN: begin
                        if (i_flags.depth_full) begin
                            n_status = ST_OVERFLOW;
                        end else if (!i_flags.scope_ok) begin
                            n_state = S_FINISH;
                        end else if (i_flags.depth_zero) begin
                            n_state = S_PUSH;
                        end else begin
                            o_cmd.stk_rd = 1'b1;
                            n_state      = S_CHG_STK;
                        end
                    end
                    OP_END: begin
                        if (i_flags.depth_zero) begin
                            n_status = ST_UNDERFLOW;
                        end else begin
                            o_cmd.stk_rd = 1'b1;
                            n_state      = S_CHG_STK;
                        end
                    end
                    OP_STEP: begin
                        if (!i_flags.depth_zero) begin
                            n_status = ST_OPEN;
                        end else begin
                            o_cmd.step_start = 1'b1;
                            o_cmd.st_rd      = 1'b1;
                            o_cmd.st_sel     = SEL_STEP0;
                            n_state          = S_STEP;
                        end
                    end
                    OP_READ: begin
                        if (i_flags.read_ok) begin
                            o_cmd.hist_rd = 1'b1;
                            n_from_hist   = 1'b1;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_CHG_STK: begin
                o_cmd.st_rd    = 1'b1;
                o_cmd.st_sel   = SEL_TOP;
                o_cmd.stk_mark = 1'b1;
                n_state        = S_CHG_WR;
            end
            S_CHG_WR: begin
                o_cmd.st_wr = WR_CHARGE;
                if (i_flags.op == OP_BEGIN) begin
                    n_state = S_PUSH;
                end else begin
                    o_cmd.depth_dec = 1'b1;
                    n_state         = S_POP;
                end
            end
            S_PUSH: begin
                o_cmd.push   = 1'b1;
                o_cmd.st_rd  = 1'b1;
                o_cmd.st_sel = SEL_SCOPE;
                n_state      = S_CALLS;
            end
            S_CALLS: begin
                o_cmd.st_wr = WR_CALL;
                n_state     = S_FINISH;
            end
            S_POP: begin
                if (i_flags.depth_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.stk_rd = 1'b1;
                    n_state      = S_INC_STK;
                end
            end
            S_INC_STK: begin
                o_cmd.st_rd    = 1'b1;
                o_cmd.st_sel   = SEL_TOP;
                o_cmd.stk_mark = 1'b1;
                n_state        = S_INC_WR;
            end
            S_INC_WR: begin
                o_cmd.st_wr = WR_INCL;
                n_state     = S_FINISH;
            end
            S_STEP: begin
                o_cmd.step_wr = 1'b1;
                if (i_flags.step_last) begin
                    o_cmd.step_done = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.step_adv = 1'b1;
                    o_cmd.st_rd    = 1'b1;
                    o_cmd.st_sel   = SEL_STEP_NEXT;
                end
            end
            S_FINISH: begin
                if (i_flags.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_hist = r_from_hist;
                    o_cmd.status   = r_status;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/nsp_dp.sv -----
// ----------------------------------------------------------------------------
// nsp_dp
// profiler datapath: scope stack, current stats, history ring, output word
// ----------------------------------------------------------------------------
module nsp_dp
    import nsp_pkg::*;
#(
    parameter int SCOPE_COUNT   = SCOPE_COUNT_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_flags              o_flags,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [SCOPE_W-1:0]  i_scope_id,
    input  logic [TIME_W-1:0]   i_timestamp,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [TIME_W-1:0]   o_own_time,
    output logic [TIME_W-1:0]   o_inclusive_time,
    output logic [CALLS_W-1:0]  o_call_count,
    output logic [HPOS_W-1:0]   o_history_position
);

    localparam int DW   = $clog2(STACK_DEPTH + 1);
    localparam int SAW  = $clog2(STACK_DEPTH);
    localparam int SW   = $clog2(SCOPE_COUNT);
    localparam int HW   = $clog2(HISTORY_DEPTH);
    localparam int FW   = $clog2(HISTORY_DEPTH + 1);
    localparam int HENT = HISTORY_DEPTH * SCOPE_COUNT;
    localparam int HAW  = $clog2(HENT);

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    // captured item
    t_op                r_op;
    logic [SCOPE_W-1:0] r_sc;
    logic [TIME_W-1:0]  r_now;
    logic [SLOT_W-1:0]  r_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_operation);
            r_sc   <= i_scope_id;
            r_now  <= i_timestamp;
            r_slot <= i_slot;
        end
    end

    // scope stack
    t_stack         m_stack [STACK_DEPTH];
    t_stack         r_stk_rd;
    logic [DW-1:0]  r_depth;
    logic [SAW-1:0] top_addr;

    assign top_addr = SAW'(r_depth - DW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.stk_rd) begin
            r_stk_rd <= m_stack[top_addr];
        end
        if (i_cmd.stk_mark) begin
            m_stack[top_addr] <= '{mark: r_now, scope: r_stk_rd.scope};
        end else if (i_cmd.push) begin
            m_stack[SAW'(r_depth)] <= '{mark: r_now, scope: r_sc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + DW'(1);
        end else if (i_cmd.depth_dec) begin
            r_depth <= r_depth - DW'(1);
        end
    end

    // current stats, entries not valid read as zero
    t_stat            m_stats [SCOPE_COUNT];
    logic [SCOPE_COUNT-1:0] r_st_vld;
    t_stat            r_st_rd;
    logic [SW-1:0]    r_step_idx;
    logic [SW-1:0]    st_raddr;
    logic [SW-1:0]    st_waddr;
    t_stat            st_wdata;
    logic [TIME_W-1:0] elapsed;

    always_comb begin
        unique case (i_cmd.st_sel)
            SEL_TOP:       st_raddr = SW'(r_stk_rd.scope);
            SEL_SCOPE:     st_raddr = SW'(r_sc);
            SEL_STEP0:     st_raddr = '0;
            SEL_STEP_NEXT: st_raddr = r_step_idx + SW'(1);
            default:       st_raddr = '0;
        endcase
    end

    assign elapsed = r_now - r_stk_rd.mark;

    always_comb begin
        st_waddr = SW'(r_stk_rd.scope);
        st_wdata = r_st_rd;
        unique case (i_cmd.st_wr)
            WR_CHARGE: begin
                st_wdata.own  = sat_add(r_st_rd.own, elapsed);
                st_wdata.incl = sat_add(r_st_rd.incl, elapsed);
            end
            WR_INCL: begin
                st_wdata.incl = sat_add(r_st_rd.incl, elapsed);
            end
            WR_CALL: begin
                st_waddr = SW'(r_sc);
                if (r_st_rd.calls != '1) begin
                    st_wdata.calls = r_st_rd.calls + CALLS_W'(1);
                end
            end
            WR_NONE: st_wdata = r_st_rd;
            default: st_wdata = r_st_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_rd) begin
            r_st_rd <= r_st_vld[st_raddr] ? m_stats[st_raddr] : '0;
        end
        if (i_cmd.st_wr != WR_NONE) begin
            m_stats[st_waddr] <= st_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= '0;
        end else if (i_cmd.step_done) begin
            r_st_vld <= '0;
        end else if (i_cmd.st_wr != WR_NONE) begin
            r_st_vld[st_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_start) begin
            r_step_idx <= '0;
        end else if (i_cmd.step_adv) begin
            r_step_idx <= r_step_idx + SW'(1);
        end
    end

    // history ring, slots below the fill count hold written rows
    t_stat          m_hist [HENT];
    t_stat          r_hist_rd;
    logic [HW-1:0]  r_hptr;
    logic [FW-1:0]  r_hfill;
    logic [HAW-1:0] h_waddr;
    logic [HAW-1:0] h_raddr;
    logic           scope_ok;

    assign h_waddr = HAW'(HAW'(r_hptr) * HAW'(SCOPE_COUNT) + HAW'(r_step_idx));
    assign h_raddr = HAW'(HAW'(r_slot) * HAW'(SCOPE_COUNT) + HAW'(r_sc));

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_wr) begin
            m_hist[h_waddr] <= r_st_rd;
        end
        if (i_cmd.hist_rd) begin
            r_hist_rd <= m_hist[h_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hptr  <= '0;
            r_hfill <= '0;
        end else if (i_cmd.step_done) begin
            r_hptr <= (r_hptr == HW'(HISTORY_DEPTH - 1)) ? '0 : r_hptr + HW'(1);
            if (r_hfill != FW'(HISTORY_DEPTH)) begin
                r_hfill <= r_hfill + FW'(1);
            end
        end
    end

    // output word
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status           <= i_cmd.status;
            o_history_position <= HPOS_W'(r_hptr);
            if (i_cmd.out_hist) begin
                o_own_time       <= r_hist_rd.own;
                o_inclusive_time <= r_hist_rd.incl;
                o_call_count     <= r_hist_rd.calls;
            end else begin
                o_own_time       <= '0;
                o_inclusive_time <= '0;
                o_call_count     <= '0;
            end
        end
    end

    assign o_out_valid = r_out_vld;

    // status back to the sequencer
    assign scope_ok = (32'(r_sc) < 32'(SCOPE_COUNT));

    assign o_flags.op         = r_op;
    assign o_flags.depth_zero = (r_depth == '0);
    assign o_flags.depth_full = (r_depth == DW'(STACK_DEPTH));
    assign o_flags.scope_ok   = scope_ok;
    assign o_flags.read_ok    = scope_ok && (32'(r_slot) < 32'(r_hfill));
    assign o_flags.step_last  = (r_step_idx == SW'(SCOPE_COUNT - 1));
    assign o_flags.out_free   = !r_out_vld || !i_out_stall;

endmodule

// ----- rtl/nsp_checker.sv -----
// ----------------------------------------------------------------------------
// nsp_checker
// port level checks of the profiler, bound to the top level
// ----------------------------------------------------------------------------
module nsp_checker
    import nsp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [TIME_W-1:0]   o_own_time,
    input logic [TIME_W-1:0]   o_inclusive_time,
    input logic [CALLS_W-1:0]  o_call_count
);

    // a taken word keeps the input side closed while it is worked
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after a word");

    // a result appears only out of a working phase
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a word in work");

    // error results carry no stats; only error status is checked here
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |->
        (o_own_time == '0 && o_inclusive_time == '0 && o_call_count == '0))
        else $error("error result with stats");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_status) && $stable(o_own_time) &&
         $stable(o_inclusive_time) && $stable(o_call_count)))
        else $error("stalled result changed");

endmodule

bind nested_scope_profiler_top nsp_checker u_nsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status         (o_status),
    .o_own_time       (o_own_time),
    .o_inclusive_time (o_inclusive_time),
    .o_call_count     (o_call_count)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the nested scope profiler: a short table of
// directed words, a stack fill to overflow, then random nested
// begin / end frames, mostly closed by a step, and a few history reads; each
// result is checked against a typed row or a software profile in the bench
// ----------------------------------------------------------------------------
module testbench;
    import nsp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = SCOPE_COUNT_DEF + 8;
    localparam int RANDOM_WORDS = 680;
    localparam int QUIET_TAIL   = 150;
    localparam int MAX_NEST     = 12;

    // one input word and one result word, at the block's widths
    typedef struct packed {
        t_op                op;
        logic [SCOPE_W-1:0] scope;
        logic [TIME_W-1:0]  ts;
        logic [SLOT_W-1:0]  slot;
    } t_prof_word;

    typedef struct packed {
        t_status            status;
        logic [TIME_W-1:0]  own;
        logic [TIME_W-1:0]  incl;
        logic [CALLS_W-1:0] calls;
        logic [HPOS_W-1:0]  hpos;
    } t_prof_result;

    // directed row: the result is typed in only where known is set
    typedef struct {
        t_prof_word   w;
        bit           known;
        t_prof_result res;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [OP_W-1:0]     i_operation;
    logic [SCOPE_W-1:0]  i_scope_id;
    logic [TIME_W-1:0]   i_timestamp;
    logic [SLOT_W-1:0]   i_slot;
    logic                o_valid;
    logic                i_stall;
    logic [STATUS_W-1:0] o_status;
    logic [TIME_W-1:0]   o_own_time;
    logic [TIME_W-1:0]   o_inclusive_time;
    logic [CALLS_W-1:0]  o_call_count;
    logic [HPOS_W-1:0]   o_history_position;

    nested_scope_profiler_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_scope_id         (i_scope_id),
        .i_timestamp        (i_timestamp),
        .i_slot             (i_slot),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_own_time         (o_own_time),
        .o_inclusive_time   (o_inclusive_time),
        .o_call_count       (o_call_count),
        .o_history_position (o_history_position)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // software profile: open scope stack, running stats, history ring
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0]  mark_stack  [STACK_DEPTH_DEF];
    logic [SCOPE_W-1:0] scope_stack [STACK_DEPTH_DEF];
    int                 open_depth;
    logic [TIME_W-1:0]  own_acc  [SCOPE_COUNT_DEF];
    logic [TIME_W-1:0]  incl_acc [SCOPE_COUNT_DEF];
    logic [CALLS_W-1:0] call_acc [SCOPE_COUNT_DEF];
    logic [TIME_W-1:0]  hist_own   [HISTORY_DEPTH_DEF][SCOPE_COUNT_DEF];
    logic [TIME_W-1:0]  hist_incl  [HISTORY_DEPTH_DEF][SCOPE_COUNT_DEF];
    logic [CALLS_W-1:0] hist_calls [HISTORY_DEPTH_DEF][SCOPE_COUNT_DEF];
    int                 hist_ptr;

    // bench bookkeeping
    t_prof_result pending_results[$];
    t_stim_row    directed[$];
    int           words_in;
    int           results_checked;
    int           fail_count;
    int           steps_done;
    int           deepest;
    int           status_count[4];
    bit           idle_on;
    logic [TIME_W-1:0] stamp_now;

    function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a,
                                                   logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    // time since the top scope's mark goes to its inclusive time, and to
    // its own time unless it is the parent of a scope just closed
    function automatic void charge_open_scope(logic [TIME_W-1:0] now, bit to_own);
        int                 top;
        logic [SCOPE_W-1:0] sc;
        logic [TIME_W-1:0]  d;
        top = open_depth - 1;
        sc  = scope_stack[top];
        d   = now - mark_stack[top];
        if (to_own)
            own_acc[sc] = sat_add(own_acc[sc], d);
        incl_acc[sc]    = sat_add(incl_acc[sc], d);
        mark_stack[top] = now;
    endfunction

    function automatic t_prof_result profile_word(t_prof_word w);
        t_prof_result r;
        r = '0;
        r.status = ST_OK;
        case (w.op)
            OP_BEGIN: begin
                if (open_depth >= STACK_DEPTH_DEF) begin
                    r.status = ST_OVERFLOW;
                end else if (w.scope < SCOPE_COUNT_DEF) begin
                    if (open_depth > 0)
                        charge_open_scope(w.ts, 1'b1);
                    mark_stack[open_depth]  = w.ts;
                    scope_stack[open_depth] = w.scope;
                    open_depth++;
                    if (call_acc[w.scope] != '1)
                        call_acc[w.scope] = call_acc[w.scope] + 1'b1;
                end
            end
            OP_END: begin
                if (open_depth == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    charge_open_scope(w.ts, 1'b1);
                    open_depth--;
                    if (open_depth > 0)
                        charge_open_scope(w.ts, 1'b0);
                end
            end
            OP_STEP: begin
                if (open_depth != 0) begin
                    r.status = ST_OPEN;
                end else begin
                    for (int i = 0; i < SCOPE_COUNT_DEF; i++) begin
                        hist_own[hist_ptr][i]   = own_acc[i];
                        hist_incl[hist_ptr][i]  = incl_acc[i];
                        hist_calls[hist_ptr][i] = call_acc[i];
                        own_acc[i]  = '0;
                        incl_acc[i] = '0;
                        call_acc[i] = '0;
                    end
                    hist_ptr = (hist_ptr + 1) % HISTORY_DEPTH_DEF;
                    steps_done++;
                end
            end
            default: begin
                if (w.scope < SCOPE_COUNT_DEF && w.slot < HISTORY_DEPTH_DEF) begin
                    r.own   = hist_own[w.slot][w.scope];
                    r.incl  = hist_incl[w.slot][w.scope];
                    r.calls = hist_calls[w.slot][w.scope];
                end
            end
        endcase
        r.hpos = HPOS_W'(hist_ptr);
        return r;
    endfunction

    function automatic t_prof_word mk_word(t_op op, logic [SCOPE_W-1:0] sc,
                                           logic [TIME_W-1:0] ts,
                                           logic [SLOT_W-1:0] slot);
        t_prof_word w;
        w.op    = op;
        w.scope = sc;
        w.ts    = ts;
        w.slot  = slot;
        return w;
    endfunction

    // typed rows always carry zero stats, so only status and position are given
    function automatic void add_row(t_op op, logic [SCOPE_W-1:0] sc,
                                    logic [TIME_W-1:0] ts, logic [SLOT_W-1:0] slot,
                                    bit known = 1'b0, t_status st = ST_OK,
                                    logic [HPOS_W-1:0] hpos = '0);
        t_stim_row row;
        row.w          = mk_word(op, sc, ts, slot);
        row.known      = known;
        row.res        = '0;
        row.res.status = st;
        row.res.hpos   = hpos;
        directed.push_back(row);
    endfunction

    // mostly small steps forward, now and then a jump anywhere (wraps too)
    function automatic logic [TIME_W-1:0] next_stamp();
        if ($urandom_range(0, 19) == 0)
            stamp_now = $urandom();
        else
            stamp_now = stamp_now + $urandom_range(0, 2000);
        return stamp_now;
    endfunction

    // ------------------------------------------------------------------------
    // sender: one word per call, driven at the falling edge, held until taken
    // ------------------------------------------------------------------------
    task automatic send_word(t_prof_word w, bit known = 1'b0,
                             t_prof_result known_res = '0);
        t_prof_result r;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= w.op;
        i_scope_id  <= w.scope;
        i_timestamp <= w.ts;
        i_slot      <= w.slot;
        // taken at the first rising edge with stall low
        do @(posedge i_clk); while (o_stall !== 1'b0);
        r = profile_word(w);
        if (known)
            r = known_res;
        pending_results.push_back(r);
        words_in++;
        status_count[r.status]++;
        if (open_depth > deepest)
            deepest = open_depth;
    endtask

    // ------------------------------------------------------------------------
    // result checker: oldest expectation against each accepted result word
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_prof_result exp_r;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    fail_count++;
                end
                if (o_own_time !== exp_r.own) begin
                    $error("own_time: expected %0d, got %0d", exp_r.own, o_own_time);
                    fail_count++;
                end
                if (o_inclusive_time !== exp_r.incl) begin
                    $error("inclusive_time: expected %0d, got %0d",
                           exp_r.incl, o_inclusive_time);
                    fail_count++;
                end
                if (o_call_count !== exp_r.calls) begin
                    $error("call_count: expected %0d, got %0d",
                           exp_r.calls, o_call_count);
                    fail_count++;
                end
                if (o_history_position !== exp_r.hpos) begin
                    $error("history_position: expected %0d, got %0d",
                           exp_r.hpos, o_history_position);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stall bursts, plus one long hold-off so the block
    // backs up and stalls its input while the sender keeps offering
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        bit long_done;
        hold_left = 0;
        long_done = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (!long_done && results_checked >= 150) begin
                long_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                i_stall   <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(0, 17);
                i_stall   <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycle counter with a generous limit
    initial begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------------
    initial begin
        int           rand_start;
        int           actions;
        int           pick;
        logic [SLOT_W-1:0] rd_slot;

        // every input known from time zero
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_READ;
        i_scope_id  = '0;
        i_timestamp = '0;
        i_slot      = '0;
        idle_on     = 1'b1;
        stamp_now   = '0;
        words_in        = 0;
        results_checked = 0;
        fail_count      = 0;
        steps_done      = 0;
        deepest         = 0;
        status_count    = '{default: 0};

        // profile after reset: empty stack, zero stats and history
        open_depth = 0;
        hist_ptr   = 0;
        for (int s = 0; s < SCOPE_COUNT_DEF; s++) begin
            own_acc[s]  = '0;
            incl_acc[s] = '0;
            call_acc[s] = '0;
            for (int h = 0; h < HISTORY_DEPTH_DEF; h++) begin
                hist_own[h][s]   = '0;
                hist_incl[h][s]  = '0;
                hist_calls[h][s] = '0;
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        // empty history right after reset, lowest and highest scope / slot
        add_row(OP_READ,  4'd0,  32'd0,        6'd0,  1'b1, ST_OK, 6'd0);
        add_row(OP_READ,  4'd15, 32'hFFFFFFFF, 6'd63, 1'b1, ST_OK, 6'd0);
        // end on an empty stack
        add_row(OP_END,   4'd0,  32'd50,       6'd0,  1'b1, ST_UNDERFLOW, 6'd0);
        // step with nothing open stores an all-zero slot
        add_row(OP_STEP,  4'd0,  32'd0,        6'd0,  1'b1, ST_OK, 6'd1);
        add_row(OP_BEGIN, 4'd3,  32'd100,      6'd0);
        // step with a scope still open
        add_row(OP_STEP,  4'd0,  32'd0,        6'd0,  1'b1, ST_OPEN, 6'd1);
        // nested scope across the 2^32 wrap, then both closed
        add_row(OP_BEGIN, 4'd15, 32'hFFFFFFF0, 6'd0);
        add_row(OP_END,   4'd0,  32'h00000010, 6'd0);
        add_row(OP_END,   4'd0,  32'hFFFFFFFF, 6'd0);
        // twice the full range on one scope saturates own and inclusive
        add_row(OP_BEGIN, 4'd0,  32'd0,        6'd0);
        add_row(OP_END,   4'd0,  32'hFFFFFFFF, 6'd0);
        add_row(OP_BEGIN, 4'd0,  32'd0,        6'd0);
        add_row(OP_END,   4'd0,  32'hFFFFFFFF, 6'd0);
        // inner scope with the parent charged inclusive only on the way out
        add_row(OP_BEGIN, 4'd10, 32'd1000,     6'd0);
        add_row(OP_BEGIN, 4'd5,  32'd1300,     6'd0);
        add_row(OP_END,   4'd0,  32'd2000,     6'd0);
        add_row(OP_END,   4'd0,  32'd2500,     6'd0);
        add_row(OP_STEP,  4'd0,  32'd0,        6'd0);
        add_row(OP_READ,  4'd0,  32'd0,        6'd1);
        add_row(OP_READ,  4'd3,  32'd0,        6'd1);
        add_row(OP_READ,  4'd15, 32'd0,        6'd1);
        add_row(OP_READ,  4'd10, 32'd0,        6'd1);
        add_row(OP_READ,  4'd5,  32'd0,        6'd1);
        add_row(OP_READ,  4'd9,  32'd0,        6'd1);
        foreach (directed[i])
            send_word(directed[i].w, directed[i].known, directed[i].res);

        // fill the stack to the top, push past it, unwind and step
        for (int k = 0; k < STACK_DEPTH_DEF + 2; k++)
            send_word(mk_word(OP_BEGIN, SCOPE_W'($urandom_range(0, 15)),
                              next_stamp(), '0));
        while (open_depth > 0)
            send_word(mk_word(OP_END, '0, next_stamp(), '0));
        send_word(mk_word(OP_STEP, '0, next_stamp(), '0));

        // random frames: nested begin / end with some noise, closed out,
        // mostly stepped into the history ring and read back
        rand_start = words_in;
        while (words_in - rand_start < RANDOM_WORDS) begin
            // every third stretch runs without gaps, and the tail is quiet
            idle_on = (words_in - rand_start < RANDOM_WORDS - QUIET_TAIL) &&
                      ((words_in / 120) % 3 != 2);
            actions = $urandom_range(1, 10);
            repeat (actions) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_word(mk_word(t_op'($urandom_range(0, 3)),
                                      SCOPE_W'($urandom_range(0, 15)), $urandom(),
                                      SLOT_W'($urandom_range(0, 63))));
                else if (open_depth == 0 || (pick < 55 && open_depth < MAX_NEST))
                    send_word(mk_word(OP_BEGIN, SCOPE_W'($urandom_range(0, 15)),
                                      next_stamp(), SLOT_W'($urandom_range(0, 63))));
                else
                    send_word(mk_word(OP_END, SCOPE_W'($urandom_range(0, 15)),
                                      next_stamp(), SLOT_W'($urandom_range(0, 63))));
            end
            while (open_depth > 0)
                send_word(mk_word(OP_END, '0, next_stamp(), '0));
            if ($urandom_range(0, 9) != 0)
                send_word(mk_word(OP_STEP, SCOPE_W'($urandom_range(0, 15)),
                                  next_stamp(), '0));
            repeat ($urandom_range(0, 3)) begin
                // mostly the slots just written, sometimes anywhere
                if ($urandom_range(0, 3) == 0)
                    rd_slot = SLOT_W'($urandom_range(0, 63));
                else
                    rd_slot = SLOT_W'(hist_ptr + HISTORY_DEPTH_DEF - 1 -
                                      $urandom_range(0, 2));
                send_word(mk_word(OP_READ, SCOPE_W'($urandom_range(0, 15)),
                                  $urandom(), rd_slot));
            end
        end
        idle_on = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then give a late extra result word a chance to show up
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words sent, %0d results checked, %0d history steps, nesting up to %0d",
                 words_in, results_checked, steps_done, deepest);
        $display("status seen: %0d overflow, %0d underflow, %0d step with open scopes",
                 status_count[ST_OVERFLOW], status_count[ST_UNDERFLOW],
                 status_count[ST_OPEN]);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
